/* sv/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define BCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/bcd_pkg.sv */
package bcd_pkg;

    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;
    localparam logic [1:0] FMT_BC3 = 2'd2;

    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam int SIZE_W = 15;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
        logic [11:0] block_column;
        logic [11:0] block_row;
    } block_word_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [13:0] pixel_x;
        logic [13:0] pixel_y;
        logic        last_pixel;
    } pixel_word_t;

    typedef struct packed {
        logic [1:0]        format;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    // One decoded block waiting for the pixel stage.
    typedef struct packed {
        logic [1:0]       format;
        rgba_t [3:0]      pal;
        logic [7:0][7:0]  atab;
        logic [63:0]      alpha_blk;
        logic [31:0]      cidx;
        logic [15:0]      mask;
        logic [11:0]      bx;
        logic [11:0]      by;
    } block_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Exact floor divisions by multiplication with a rounded-up reciprocal.
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'd8625630;
        return p[27:20];
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'd4244475;
        return p[27:20];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd13108;
        return p[23:16];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd9363;
        return p[23:16];
    endfunction

endpackage

/* sv/bc_block_texture_decoder.sv */
// channel | dir | handshake            | word
// in      | in  | in_valid / in_stall   | block_word_t: one 16-byte block and its place
// out     | out | out_valid / out_stall | pixel_word_t: one pixel, last_pixel on the final one
// cfg     | in  | cfg_write             | cfg_index selects format, width or height
// The output carries one pixel per cycle unless out_stall holds it: a block emits each
// of its pixels that lie in the image, and a block fully outside the image emits none.
// A block's first pixel passes the stage-one registers, the queue and the output register.
// Front, two-entry block queue and pixel stage stall independently; out_stall holds the
// output register while the front keeps taking words until the queue fills.
// rst_n clears all control state at once; no clearing pass follows.
module bc_block_texture_decoder #(
    parameter int MAX_IMAGE_SIDE = 16384
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  bcd_pkg::block_word_t            in_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output bcd_pkg::pixel_word_t            out_word,
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [bcd_pkg::SIZE_W-1:0]      cfg_data
);

    bcd_pkg::cfg_t          cfg_reg;
    bcd_pkg::cfg_t          cfg_next;
    logic                   push;
    logic                   pop;
    bcd_pkg::block_entry_t  push_word;
    bcd_pkg::block_entry_t  head;
    bcd_pkg::queue_status_t q_status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                bcd_pkg::CFG_FORMAT: cfg_next.format = cfg_data[1:0];
                bcd_pkg::CFG_WIDTH:  cfg_next.width  = cfg_data;
                bcd_pkg::CFG_HEIGHT: cfg_next.height = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.format <= bcd_pkg::FMT_BC1;
            cfg_reg.width  <= bcd_pkg::SIZE_W'(16384);
            cfg_reg.height <= bcd_pkg::SIZE_W'(16384);
        end
        else
            cfg_reg <= cfg_next;
    end

    bcd_front #(
        .MAX_IMAGE_SIDE(MAX_IMAGE_SIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .push      (push),
        .push_word (push_word)
    );

    bcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    bcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

/* sv/bcd_front.sv */
module bcd_front #(
    parameter int MAX_IMAGE_SIDE = 16384
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bcd_pkg::block_word_t  in_word,
    input  bcd_pkg::cfg_t         cfg,
    input  bcd_pkg::queue_status_t q_status,
    output logic                  push,
    output bcd_pkg::block_entry_t push_word
);

    localparam int SIDE_W = $clog2(MAX_IMAGE_SIDE + 1);
    localparam int CMP_W  = (SIDE_W > bcd_pkg::SIZE_W) ? SIDE_W : bcd_pkg::SIZE_W;
    localparam logic [CMP_W-1:0] SIDE_MAX = CMP_W'(MAX_IMAGE_SIDE);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              load;

    logic [1:0]        fmt_reg;
    logic              four_reg;
    logic [2:0][7:0]   e0_reg;
    logic [2:0][7:0]   e1_reg;
    logic [31:0]       cidx_reg;
    logic [63:0]       lo_reg;
    logic [15:0]       mask_reg;
    logic [11:0]       bx_reg;
    logic [11:0]       by_reg;

    logic [1:0]        fmt_n;
    logic [63:0]       cblock;
    logic [CMP_W-1:0]  w_sat;
    logic [CMP_W-1:0]  h_sat;
    logic [3:0]        col_ok;
    logic [3:0]        row_ok;
    logic [15:0]       mask_n;
    logic [2:0][7:0]   e0_n;
    logic [2:0][7:0]   e1_n;

    logic [7:0]        a0;
    logic [7:0]        a1;
    logic [7:0][7:0]   atab;
    logic [6:1][7:0]   t7;
    logic [4:1][7:0]   t5;
    bcd_pkg::rgba_t [3:0] pal;

    // Stage one: classify the word, expand endpoints, work out clipping.
    always_comb
    begin
        fmt_n = (cfg.format == bcd_pkg::FMT_BC2 || cfg.format == bcd_pkg::FMT_BC3) ?
                cfg.format : bcd_pkg::FMT_BC1;
        cblock = (fmt_n == bcd_pkg::FMT_BC1) ? in_word.block_low : in_word.block_high;
        e0_n[0] = bcd_pkg::expand5(cblock[15:11]);
        e0_n[1] = bcd_pkg::expand6(cblock[10:5]);
        e0_n[2] = bcd_pkg::expand5(cblock[4:0]);
        e1_n[0] = bcd_pkg::expand5(cblock[31:27]);
        e1_n[1] = bcd_pkg::expand6(cblock[26:21]);
        e1_n[2] = bcd_pkg::expand5(cblock[20:16]);
        w_sat = (CMP_W'(cfg.width) > SIDE_MAX) ? SIDE_MAX : CMP_W'(cfg.width);
        h_sat = (CMP_W'(cfg.height) > SIDE_MAX) ? SIDE_MAX : CMP_W'(cfg.height);
        for (int i = 0; i < 4; i++)
        begin
            col_ok[i] = CMP_W'({in_word.block_column, 2'(i)}) < w_sat;
            row_ok[i] = CMP_W'({in_word.block_row, 2'(i)}) < h_sat;
        end
        for (int i = 0; i < 16; i++)
            mask_n[i] = col_ok[i % 4] & row_ok[i / 4];
    end

    assign in_stall = s1_valid_reg && q_status.full;
    assign load     = !in_stall;
    assign push     = s1_valid_reg && !q_status.full;
    assign s1_valid_next = load ? in_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            fmt_reg  <= fmt_n;
            four_reg <= (cblock[15:0] > cblock[31:16]) || (fmt_n != bcd_pkg::FMT_BC1);
            e0_reg   <= e0_n;
            e1_reg   <= e1_n;
            cidx_reg <= cblock[63:32];
            lo_reg   <= in_word.block_low;
            mask_reg <= mask_n;
            bx_reg   <= in_word.block_column;
            by_reg   <= in_word.block_row;
        end
    end

    // Stage two: palette and alpha table, straight into the queue.
    always_comb
    begin
        pal[0] = '{r: e0_reg[0], g: e0_reg[1], b: e0_reg[2], a: 8'd255};
        pal[1] = '{r: e1_reg[0], g: e1_reg[1], b: e1_reg[2], a: 8'd255};
        pal[2].a = 8'd255;
        pal[3].a = four_reg ? 8'd255 : 8'd0;
        for (int c = 0; c < 3; c++)
        begin
            if (four_reg)
            begin
                pal[2][8*(3-c) +: 8] = bcd_pkg::div3({1'b0, e0_reg[c], 1'b0}
                                                     + 10'(e1_reg[c]));
                pal[3][8*(3-c) +: 8] = bcd_pkg::div3(10'(e0_reg[c])
                                                     + {1'b0, e1_reg[c], 1'b0});
            end
            else
            begin
                pal[2][8*(3-c) +: 8] = 8'((9'(e0_reg[c]) + 9'(e1_reg[c])) >> 1);
                pal[3][8*(3-c) +: 8] = 8'd0;
            end
        end

        a0 = lo_reg[7:0];
        a1 = lo_reg[15:8];
        for (int k = 1; k <= 6; k++)
            t7[k] = bcd_pkg::div7(11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1));
        for (int k = 1; k <= 4; k++)
            t5[k] = bcd_pkg::div5(11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1));
        atab[0] = a0;
        atab[1] = a1;
        for (int k = 1; k <= 4; k++)
            atab[k + 1] = (a0 > a1) ? t7[k] : t5[k];
        atab[6] = (a0 > a1) ? t7[5] : 8'd0;
        atab[7] = (a0 > a1) ? t7[6] : 8'd255;

        push_word.format    = fmt_reg;
        push_word.pal       = pal;
        push_word.atab      = atab;
        push_word.alpha_blk = lo_reg;
        push_word.cidx      = cidx_reg;
        push_word.mask      = mask_reg;
        push_word.bx        = bx_reg;
        push_word.by        = by_reg;
    end

endmodule

/* sv/bcd_queue.sv */
module bcd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bcd_pkg::block_entry_t  push_word,
    input  logic                   pop,
    output bcd_pkg::block_entry_t  head,
    output bcd_pkg::queue_status_t status
);

    bcd_pkg::block_entry_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    assign status.full  = count_reg == 2'd2;
    assign status.empty = count_reg == 2'd0;
    assign head = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_word;
    end

endmodule

/* sv/bcd_back.sv */
module bcd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bcd_pkg::block_entry_t  head,
    input  bcd_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output bcd_pkg::pixel_word_t   out_word
);

    logic [15:0]          done_reg;
    logic [15:0]          done_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    bcd_pkg::pixel_word_t out_word_reg;

    logic [15:0]          pending;
    logic [15:0]          pick;
    logic [3:0]           idx;
    logic                 out_free;
    logic                 emit;
    logic                 last;
    logic [1:0]           ci;
    logic [3:0]           nib;
    logic [2:0]           aidx;
    bcd_pkg::rgba_t       color;
    bcd_pkg::pixel_word_t pix;

    always_comb
    begin
        pending = head.mask & ~done_reg;
        idx = 4'd0;
        for (int i = 15; i >= 0; i--)
        begin
            if (pending[i])
                idx = 4'(i);
        end
        pick = 16'd1 << idx;
        out_free = !out_valid_reg || !out_stall;
        emit = !q_status.empty && (pending != 16'd0) && out_free;
        last = (pending & ~pick) == 16'd0;
        // A block with nothing in the image leaves without a pixel.
        pop = !q_status.empty && ((pending == 16'd0) || (emit && last));
        done_next = pop ? 16'd0 : (emit ? (done_reg | pick) : done_reg);
        out_valid_next = emit ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

        ci    = head.cidx[2*idx +: 2];
        nib   = head.alpha_blk[4*idx +: 4];
        aidx  = head.alpha_blk[16 + 3*idx +: 3];
        color = head.pal[ci];
        pix.red   = color.r;
        pix.green = color.g;
        pix.blue  = color.b;
        unique case (head.format)
            bcd_pkg::FMT_BC2: pix.alpha = {nib, nib};
            bcd_pkg::FMT_BC3: pix.alpha = head.atab[aidx];
            default:          pix.alpha = color.a;
        endcase
        pix.pixel_x    = {head.bx, idx[1:0]};
        pix.pixel_y    = {head.by, idx[3:2]};
        pix.last_pixel = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_word_reg <= pix;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

/* sv/bcd_checker.sv */
`include "assert_macros.svh"

module bcd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input bcd_pkg::block_word_t       in_word,
    input logic                       out_valid,
    input logic                       out_stall,
    input bcd_pkg::pixel_word_t       out_word,
    input logic                       cfg_write,
    input logic [1:0]                 cfg_index,
    input logic [bcd_pkg::SIZE_W-1:0] cfg_data
);

    logic        mid_block;
    logic        stalled;
    logic [3:0]  texel;
    logic [23:0] tile;

    assign mid_block = out_valid && !out_stall && !out_word.last_pixel;
    assign stalled   = out_valid && out_stall;
    assign texel = {out_word.pixel_y[1:0], out_word.pixel_x[1:0]};
    assign tile  = {out_word.pixel_y[13:2], out_word.pixel_x[13:2]};

    `BCD_ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |=> !out_valid, "output valid after reset")
    `BCD_ASSERT(a_valid_holds, clk, rst_n, stalled |=> out_valid, "valid dropped while stalled")
    `BCD_ASSERT(a_word_holds, clk, rst_n, stalled |=> $stable(out_word), "word changed in stall")
    `BCD_ASSERT(a_same_block, clk, rst_n, mid_block |=> tile == $past(tile), "block left early")
    `BCD_ASSERT(a_row_major, clk, rst_n, mid_block |=> !out_valid || texel > $past(texel),
                "pixels out of row-major order")

endmodule

bind bc_block_texture_decoder bcd_checker u_bcd_checker (.*);
